// ===== src/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// types, constants and round tables shared by the md5 digest core
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

    typedef logic [31:0] t_word;

    // one input item
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    // item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // shared unit operations
    localparam logic ALU_ADD3   = 1'b0;
    localparam logic ALU_ROTADD = 1'b1;

    // request to the shared adder unit
    typedef struct packed {
        logic        op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [4:0]  sh;
    } t_alu_req;

    // block store write port
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } t_blk_wr;

    localparam t_word IV [0:3] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam t_word SINE_TAB [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // per-round rotate amount, four per group of sixteen rounds
    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        case (r[5:4])
            2'd0: begin
                case (r[1:0])
                    2'd0: s = 5'd7;
                    2'd1: s = 5'd12;
                    2'd2: s = 5'd17;
                    default: s = 5'd22;
                endcase
            end
            2'd1: begin
                case (r[1:0])
                    2'd0: s = 5'd5;
                    2'd1: s = 5'd9;
                    2'd2: s = 5'd14;
                    default: s = 5'd20;
                endcase
            end
            2'd2: begin
                case (r[1:0])
                    2'd0: s = 5'd4;
                    2'd1: s = 5'd11;
                    2'd2: s = 5'd16;
                    default: s = 5'd23;
                endcase
            end
            default: begin
                case (r[1:0])
                    2'd0: s = 5'd6;
                    2'd1: s = 5'd10;
                    2'd2: s = 5'd15;
                    default: s = 5'd21;
                endcase
            end
        endcase
        return s;
    endfunction

    // message word used in a round
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] g;
        lo = r[3:0];
        case (r[5:4])
            2'd0:    g = lo;
            2'd1:    g = (lo << 2) + lo + 4'd1;
            2'd2:    g = (lo << 1) + lo + 4'd5;
            default: g = (lo << 3) - lo;
        endcase
        return g;
    endfunction

    // nonlinear round function
    function automatic t_word round_fn(input logic [5:0] r, input t_word b,
                                       input t_word c, input t_word d);
        t_word f;
        case (r[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== src/md5_alu.sv =====
// ----------------------------------------------------------------------------
// md5_alu
// shared 32-bit adder: three-operand add, or rotate-left then add
// ----------------------------------------------------------------------------
`default_nettype none

module md5_alu (
    input  md5_pkg::t_alu_req i_req,
    output logic [31:0]       o_res
);

    logic [63:0] rot_wide;

    always_comb begin
        rot_wide = {i_req.x, i_req.x} << i_req.sh;
        if (i_req.op == md5_pkg::ALU_ROTADD) begin
            o_res = i_req.y + rot_wide[63:32];
        end else begin
            o_res = i_req.x + i_req.y + i_req.z;
        end
    end

endmodule

`default_nettype wire

// ===== src/md5_block_store.sv =====
// ----------------------------------------------------------------------------
// md5_block_store
// sixteen-word message block memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module md5_block_store (
    input  logic             i_clk,
    input  md5_pkg::t_blk_wr i_wr,
    input  logic             i_rd_en,
    input  logic [3:0]       i_rd_addr,
    output logic [31:0]      o_rd_data
);

    logic [31:0] mem [0:15];
    logic [31:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

`default_nettype wire

// ===== src/md5_digest_core.sv =====
// ----------------------------------------------------------------------------
// md5_digest_core
// md5 digest of a byte stream, one byte per item, rounds on a shared adder
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------
//  input     in         i_in_valid / o_in_ready    i_in  (kind, data_byte)
//  output    out        o_out_valid / i_out_ready  o_out (digest_word,
//                                                         word_index, last_word)
//
//  a data byte is taken while idle; the byte that fills the block starts a
//  compression of 64 rounds of three phases each plus a four-step chaining
//  update, serialized by the single shared adder and the one-read-port store
//  an end item takes up to 16 padding writes per block, one or two
//  compressions, and then four output items, each waiting on i_out_ready
//  reset (i_rst_n low, synchronous) loads the initial chaining value and
//  clears the byte count; the block store holds no reset
//  o_in_ready is high only while idle, so no item enters during a compression
//  or while digest words are pending
//
`default_nettype none

module md5_digest_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  md5_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output md5_pkg::t_out_item  o_out
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;   // taking items
    localparam logic [2:0] S_PAD  = 3'd1;   // writing padding words
    localparam logic [2:0] S_RND  = 3'd2;   // 64 rounds
    localparam logic [2:0] S_ADD  = 3'd3;   // chaining value update
    localparam logic [2:0] S_OUT  = 3'd4;   // digest words out

    // round phases
    localparam logic [1:0] PH_SUM_A  = 2'd0; // tmp = a + k, fetch message word
    localparam logic [1:0] PH_SUM_FM = 2'd1; // tmp += f + m
    localparam logic [1:0] PH_ROT    = 2'd2; // b' = b + rotl(tmp)

    logic [2:0]  r_state, n_state;
    logic [63:0] r_count, n_count;      // message bytes so far
    logic [31:0] r_word, n_word;        // word being assembled from bytes
    logic [3:0]  r_wp, n_wp;            // padding word pointer
    logic        r_first, n_first;      // next pad word carries the terminator
    logic        r_two, n_two;          // padding spills into a second block
    logic        r_final, n_final;      // compression belongs to the end item
    logic [5:0]  r_round, n_round;
    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_tmp, n_tmp;
    logic [31:0] r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d;
    logic [31:0] r_cv [0:3];
    logic [31:0] n_cv [0:3];
    logic [1:0]  r_oidx, n_oidx;

    md5_pkg::t_alu_req alu_req;
    logic [31:0]       alu_res;
    md5_pkg::t_blk_wr  blk_wr;
    logic              rd_en;
    logic [3:0]        rd_addr;
    logic [31:0]       rd_data;

    logic        in_fire;
    logic        out_fire;
    logic [5:0]  pos;
    logic [4:0]  byte_sh;
    logic [31:0] asm_word;
    logic [31:0] term_word;
    logic [63:0] bit_len;
    logic [31:0] pad_word;

    md5_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    md5_block_store u_store (
        .i_clk     (i_clk),
        .i_wr      (blk_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;

    // digest words leave from the head of the rotating chaining registers
    assign o_out.digest_word = r_cv[0];
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = (r_oidx == 2'd3);

    // byte placement inside the current word, little-endian
    assign pos      = r_count[5:0];
    assign byte_sh  = {pos[1:0], 3'b000};
    assign asm_word = (pos[1:0] == 2'd0) ? {24'd0, i_in.data_byte}
                                         : r_word | ({24'd0, i_in.data_byte} << byte_sh);
    assign term_word = (pos[1:0] == 2'd0) ? {24'd0, md5_pkg::PAD_BYTE}
                                          : r_word | ({24'd0, md5_pkg::PAD_BYTE} << byte_sh);
    assign bit_len  = {r_count[60:0], 3'b000};

    // padding word: terminator word first, length in words 14 and 15 of the
    // last block, zero elsewhere
    always_comb begin
        if (r_first) begin
            pad_word = r_word;
        end else if (!r_two && r_wp == 4'd14) begin
            pad_word = bit_len[31:0];
        end else if (!r_two && r_wp == 4'd15) begin
            pad_word = bit_len[63:32];
        end else begin
            pad_word = 32'd0;
        end
    end

    // block store write port
    always_comb begin
        blk_wr.en   = 1'b0;
        blk_wr.addr = pos[5:2];
        blk_wr.data = asm_word;
        if (r_state == S_IDLE) begin
            blk_wr.en = in_fire && (i_in.kind == md5_pkg::KIND_DATA) && (pos[1:0] == 2'd3);
        end else if (r_state == S_PAD) begin
            blk_wr.en   = 1'b1;
            blk_wr.addr = r_wp;
            blk_wr.data = pad_word;
        end
    end

    // message word fetch happens in the first phase of each round
    assign rd_en   = (r_state == S_RND) && (r_phase == PH_SUM_A);
    assign rd_addr = md5_pkg::msg_index(r_round);

    // shared adder operand selection
    always_comb begin
        alu_req.op = md5_pkg::ALU_ADD3;
        alu_req.x  = r_a;
        alu_req.y  = md5_pkg::SINE_TAB[r_round];
        alu_req.z  = 32'd0;
        alu_req.sh = md5_pkg::rot_amount(r_round);
        if (r_state == S_RND) begin
            case (r_phase)
                PH_SUM_A: begin
                    alu_req.x = r_a;
                end
                PH_SUM_FM: begin
                    alu_req.x = r_tmp;
                    alu_req.y = md5_pkg::round_fn(r_round, r_b, r_c, r_d);
                    alu_req.z = rd_data;
                end
                PH_ROT: begin
                    alu_req.op = md5_pkg::ALU_ROTADD;
                    alu_req.x  = r_tmp;
                    alu_req.y  = r_b;
                end
                default: begin
                    alu_req.x = r_a;
                end
            endcase
        end else if (r_state == S_ADD) begin
            // chaining add: cv head plus work register a
            alu_req.x = r_cv[0];
            alu_req.y = r_a;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_word  = r_word;
        n_wp    = r_wp;
        n_first = r_first;
        n_two   = r_two;
        n_final = r_final;
        n_round = r_round;
        n_phase = r_phase;
        n_tmp   = r_tmp;
        n_a     = r_a;
        n_b     = r_b;
        n_c     = r_c;
        n_d     = r_d;
        n_oidx  = r_oidx;
        for (int k = 0; k < 4; k++) begin
            n_cv[k] = r_cv[k];
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.kind == md5_pkg::KIND_DATA) begin
                        n_word  = asm_word;
                        n_count = r_count + 64'd1;
                        if (pos == 6'd63) begin
                            // block full, compress it
                            n_final = 1'b0;
                            n_round = 6'd0;
                            n_phase = PH_SUM_A;
                            n_a     = r_cv[0];
                            n_b     = r_cv[1];
                            n_c     = r_cv[2];
                            n_d     = r_cv[3];
                            n_state = S_RND;
                        end
                    end else begin
                        // end of message: fill the rest of the block
                        n_word  = term_word;
                        n_wp    = pos[5:2];
                        n_first = 1'b1;
                        n_two   = (pos[5:3] == 3'd7);
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_first = 1'b0;
                n_wp    = r_wp + 4'd1;
                if (r_wp == 4'd15) begin
                    n_final = 1'b1;
                    n_round = 6'd0;
                    n_phase = PH_SUM_A;
                    n_a     = r_cv[0];
                    n_b     = r_cv[1];
                    n_c     = r_cv[2];
                    n_d     = r_cv[3];
                    n_state = S_RND;
                end
            end
            S_RND: begin
                case (r_phase)
                    PH_SUM_A: begin
                        n_tmp   = alu_res;
                        n_phase = PH_SUM_FM;
                    end
                    PH_SUM_FM: begin
                        n_tmp   = alu_res;
                        n_phase = PH_ROT;
                    end
                    PH_ROT: begin
                        n_a     = r_d;
                        n_b     = alu_res;
                        n_c     = r_b;
                        n_d     = r_c;
                        n_phase = PH_SUM_A;
                        n_round = r_round + 6'd1;
                        if (r_round == 6'd63) begin
                            n_round = 6'd0;
                            n_state = S_ADD;
                        end
                    end
                    default: begin
                        n_phase = PH_SUM_A;
                    end
                endcase
            end
            S_ADD: begin
                // rotate both register sets; after four steps order is restored
                n_cv[0] = r_cv[1];
                n_cv[1] = r_cv[2];
                n_cv[2] = r_cv[3];
                n_cv[3] = alu_res;
                n_a     = r_b;
                n_b     = r_c;
                n_c     = r_d;
                n_d     = r_a;
                n_round = r_round + 6'd1;
                if (r_round[1:0] == 2'd3) begin
                    n_round = 6'd0;
                    if (!r_final) begin
                        n_state = S_IDLE;
                    end else if (r_two) begin
                        // second padding block: zeros and the length
                        n_two   = 1'b0;
                        n_wp    = 4'd0;
                        n_state = S_PAD;
                    end else begin
                        n_oidx  = 2'd0;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (out_fire) begin
                    n_oidx  = r_oidx + 2'd1;
                    n_cv[0] = r_cv[1];
                    n_cv[1] = r_cv[2];
                    n_cv[2] = r_cv[3];
                    n_cv[3] = r_cv[0];
                    if (r_oidx == 2'd3) begin
                        // next message starts fresh
                        for (int k = 0; k < 4; k++) begin
                            n_cv[k] = md5_pkg::IV[k];
                        end
                        n_count = 64'd0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= 64'd0;
            r_first <= 1'b0;
            r_two   <= 1'b0;
            r_final <= 1'b0;
            r_round <= 6'd0;
            r_phase <= PH_SUM_A;
            r_oidx  <= 2'd0;
            r_a     <= 32'd0;
            r_b     <= 32'd0;
            r_c     <= 32'd0;
            r_d     <= 32'd0;
            for (int k = 0; k < 4; k++) begin
                r_cv[k] <= md5_pkg::IV[k];
            end
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_first <= n_first;
            r_two   <= n_two;
            r_final <= n_final;
            r_round <= n_round;
            r_phase <= n_phase;
            r_oidx  <= n_oidx;
            r_a     <= n_a;
            r_b     <= n_b;
            r_c     <= n_c;
            r_d     <= n_d;
            for (int k = 0; k < 4; k++) begin
                r_cv[k] <= n_cv[k];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_wp   <= n_wp;
        r_tmp  <= n_tmp;
    end

endmodule

`default_nettype wire

// ===== src/md5_digest_checker.sv =====
// ----------------------------------------------------------------------------
// md5_digest_checker
// port-level checks on the md5 digest core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module md5_digest_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input md5_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input md5_pkg::t_out_item o_out
);

    // no new item while digest words are pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while digest words pending");

    // last flag only on word three
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last_word == (o_out.word_index == 2'd3)))
        else $error("last_word does not match word_index");

    // digest words come out in order without gaps
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.last_word) |=>
        (o_out_valid && o_out.word_index == 2'($past(o_out.word_index) + 2'd1)))
        else $error("digest word sequence broken");

    // an end item always keeps the block busy afterwards
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.kind == md5_pkg::KIND_END) |=> !o_in_ready)
        else $error("ready right after end of message");

    // stalled output item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("output item changed while stalled");

endmodule

bind md5_digest_core md5_digest_checker u_md5_digest_checker (.*);

`default_nettype wire
